FILE: src/bounded_circular_list_engine_defines.svh
// Assertion helpers for the circular list engine.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef BOUNDED_CIRCULAR_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_CIRCULAR_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BCLE_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define BCLE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/bcle_pkg.sv
package bcle_pkg;

	// Default list capacity and the widest cell index over the allowed range
	localparam int CAPACITY_DEF = 16;
	localparam int IDX_MAXW     = 8;

	typedef enum logic [2:0] {
		CMD_INS_FRONT = 3'd0,
		CMD_INS_BACK  = 3'd1,
		CMD_REM_FRONT = 3'd2,
		CMD_REM_BACK  = 3'd3,
		CMD_REM_VALUE = 3'd4,
		CMD_SEARCH    = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// Operation broadcast to every cell of the chain
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_ROTATE,
		CELL_WRITE,
		CELL_CLOSE
	} cell_op_t;

	typedef struct packed {
		cell_op_t              op;
		logic [IDX_MAXW-1:0]   idx;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_CLOSE,
		S_RESP
	} state_t;

endpackage

FILE: src/bcle_cell.sv
module bcle_cell #(
	parameter int INDEX = 0
) (
	input  logic              clk,
	input  bcle_pkg::cell_ctl_t ctl,
	input  logic [31:0]       wr_data,
	input  logic [31:0]       left_in,
	input  logic [31:0]       right_in,
	output logic [31:0]       data
);
	import bcle_pkg::*;

	logic [31:0] data_q;

	// Take from a neighbor or the write bus as the broadcast operation says
	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_PUSH: begin
				data_q <= left_in;
			end
			CELL_ROTATE: begin
				data_q <= right_in;
			end
			CELL_WRITE: begin
				if (ctl.idx == IDX_MAXW'(INDEX)) begin
					data_q <= wr_data;
				end
			end
			CELL_CLOSE: begin
				if (ctl.idx <= IDX_MAXW'(INDEX)) begin
					data_q <= right_in;
				end
			end
			default: begin
			end
		endcase
	end

	assign data = data_q;

endmodule

FILE: src/bounded_circular_list_engine.sv
// Inserts, remove front, remove back on an empty list and unused commands go from
// S_EXEC straight to S_RESP, where done is high; remove back on a non-empty list,
// remove value and search first pass through S_SCAN, one full rotation of the cell
// ring past cell 0 for the compare, and then through S_CLOSE before S_RESP.
// A new transaction may start in the cycle done is high; the receiver cannot stall.
// Reset (arst_n low) empties the list; stored values are undefined until written.
`include "bounded_circular_list_engine_defines.svh"

module bounded_circular_list_engine #(
	parameter int CAPACITY = bcle_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         command,
	input  logic signed [31:0] value,
	output logic               done,
	output logic [1:0]         status,
	output logic signed [31:0] removed_value,
	output logic [3:0]         position,
	output logic [4:0]         count
);
	import bcle_pkg::*;

	localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNTW = $clog2(CAPACITY + 1);

	state_t          state_q, state_d;
	logic [CNTW-1:0] cnt_q, cnt_d;
	cmd_t            cmd_q;
	logic [31:0]     key_q;
	logic [IDXW-1:0] step_q;
	logic            found_q;
	status_t         status_q;
	logic [31:0]     removed_q;
	logic [IDXW-1:0] pos_q;
	cell_ctl_t       ctl;
	logic            accept;
	logic            full;
	logic            empty;
	logic            last_step;
	logic            step_in_list;
	logic            step_is_last_entry;
	logic [31:0]     cell_data [CAPACITY];

	assign busy      = (state_q != S_IDLE) && (state_q != S_RESP);
	assign accept    = start && !busy;
	assign full      = (cnt_q == CNTW'(CAPACITY));
	assign empty     = (cnt_q == '0);
	assign last_step = (step_q == IDXW'(CAPACITY - 1));
	assign step_in_list       = (CNTW'(step_q) < cnt_q);
	assign step_is_last_entry = (CNTW'(step_q) == (cnt_q - CNTW'(1)));

	// Chain of cells: left neighbor feeds a front insert, right neighbor a rotate or close
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [31:0] left_w;
		logic [31:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = key_q;
		end else begin : g_mid
			assign left_w = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = cell_data[0];
		end else begin : g_inner
			assign right_w = cell_data[i+1];
		end
		bcle_cell #(
			.INDEX(i)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.wr_data (key_q),
			.left_in (left_w),
			.right_in(right_w),
			.data    (cell_data[i])
		);
	end

	// Hold state and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state, count and cell operation
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		ctl.op  = CELL_HOLD;
		ctl.idx = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (cmd_q)
					CMD_INS_FRONT, CMD_INS_BACK: begin
						state_d = S_RESP;
						if (!full) begin
							ctl.op  = (cmd_q == CMD_INS_FRONT) ? CELL_PUSH : CELL_WRITE;
							ctl.idx = IDX_MAXW'(cnt_q);
							cnt_d   = cnt_q + CNTW'(1);
						end
					end
					CMD_REM_FRONT: begin
						state_d = S_RESP;
						if (!empty) begin
							ctl.op = CELL_CLOSE;
							cnt_d  = cnt_q - CNTW'(1);
						end
					end
					CMD_REM_BACK: begin
						state_d = empty ? S_RESP : S_SCAN;
					end
					CMD_REM_VALUE, CMD_SEARCH: begin
						state_d = S_SCAN;
					end
					default: begin
						state_d = S_RESP;
					end
				endcase
			end
			S_SCAN: begin
				ctl.op = CELL_ROTATE;
				if (last_step) begin
					state_d = S_CLOSE;
				end
			end
			S_CLOSE: begin
				state_d = S_RESP;
				if (found_q && ((cmd_q == CMD_REM_BACK) || (cmd_q == CMD_REM_VALUE))) begin
					ctl.op  = CELL_CLOSE;
					ctl.idx = IDX_MAXW'(pos_q);
					cnt_d   = cnt_q - CNTW'(1);
				end
			end
			S_RESP: begin
				state_d = start ? S_EXEC : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				S_EXEC: begin
					step_q  <= '0;
					found_q <= 1'b0;
				end
				S_SCAN: begin
					step_q <= IDXW'(step_q + 1'b1);
					if (!found_q && step_in_list &&
						((cmd_q == CMD_REM_BACK) ? step_is_last_entry
							: (cell_data[0] == key_q))) begin
						found_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Capture the transaction and build the result
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(command);
			key_q <= value;
		end
		case (state_q)
			S_EXEC: begin
				pos_q <= '0;
				case (cmd_q)
					CMD_INS_FRONT, CMD_INS_BACK: begin
						status_q  <= full ? ST_FULL : ST_OK;
						removed_q <= '0;
					end
					CMD_REM_FRONT: begin
						status_q  <= empty ? ST_EMPTY : ST_OK;
						removed_q <= empty ? 32'd0 : cell_data[0];
					end
					CMD_REM_BACK: begin
						status_q  <= empty ? ST_EMPTY : ST_OK;
						removed_q <= '0;
					end
					default: begin
						status_q  <= ST_OK;
						removed_q <= '0;
					end
				endcase
			end
			S_SCAN: begin
				// Cell 0 holds the entry at index step_q during the rotation
				if (!found_q && step_in_list &&
					((cmd_q == CMD_REM_BACK) ? step_is_last_entry
						: (cell_data[0] == key_q))) begin
					pos_q <= step_q;
					if (cmd_q != CMD_SEARCH) begin
						removed_q <= cell_data[0];
					end
				end
			end
			S_CLOSE: begin
				if (!found_q && ((cmd_q == CMD_REM_VALUE) || (cmd_q == CMD_SEARCH))) begin
					status_q <= ST_NOTFOUND;
				end
			end
			default: begin
			end
		endcase
	end

	assign done          = (state_q == S_RESP);
	assign status        = status_q;
	assign removed_value = removed_q;
	assign position      = 4'(pos_q);
	assign count         = 5'(cnt_q);

	`BCLE_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CNTW'(CAPACITY), "entry count above capacity")
	`BCLE_ASSERT_IMPL(a_full_count, done && (status == ST_FULL), full, "full reported below capacity")
	`BCLE_ASSERT_IMPL(a_empty_count, done && (status == ST_EMPTY), empty, "empty reported with entries")
	`BCLE_ASSERT_NEXT(a_accept_busy, accept, busy && !done, "accepted transaction not in progress")

endmodule
